// ===== hdl/z80_instruction_stream_decoder_macros.svh =====
// Assertion macros shared by the decoder modules
`ifndef Z80_INSTRUCTION_STREAM_DECODER_MACROS_SVH
`define Z80_INSTRUCTION_STREAM_DECODER_MACROS_SVH

// implication checked every edge outside reset
`define Z80D_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("z80 decoder check failed");

// next-cycle implication
`define Z80D_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("z80 decoder check failed");

`endif

// ===== hdl/z80d_pkg.sv =====
// ----------------------------------------------------------------------------
// z80d_pkg
// Types, codes and opcode classification functions of the Z80 stream decoder.
// ----------------------------------------------------------------------------
package z80d_pkg;

	localparam logic [2:0] PH_OP     = 3'd0;
	localparam logic [2:0] PH_CBDISP = 3'd1;
	localparam logic [2:0] PH_CBOP   = 3'd2;
	localparam logic [2:0] PH_EDOP   = 3'd3;
	localparam logic [2:0] PH_DISP   = 3'd4;
	localparam logic [2:0] PH_IMMLO  = 3'd5;
	localparam logic [2:0] PH_IMMHI  = 3'd6;

	localparam logic [1:0] PAGE_BASE = 2'd0;
	localparam logic [1:0] PAGE_CB   = 2'd1;
	localparam logic [1:0] PAGE_ED   = 2'd2;

	localparam logic [1:0] IDX_HL = 2'd0;
	localparam logic [1:0] IDX_IX = 2'd1;
	localparam logic [1:0] IDX_IY = 2'd2;

	localparam logic [1:0] IMM_NONE = 2'd0;
	localparam logic [1:0] IMM_BYTE = 2'd1;
	localparam logic [1:0] IMM_WORD = 2'd2;
	localparam logic [1:0] IMM_REL  = 2'd3;

	localparam logic [7:0] OP_CB   = 8'hCB;
	localparam logic [7:0] OP_ED   = 8'hED;
	localparam logic [7:0] OP_DD   = 8'hDD;
	localparam logic [7:0] OP_FD   = 8'hFD;
	localparam logic [7:0] OP_HALT = 8'h76;
	localparam logic [7:0] OP_CALL = 8'hCD;

	// instruction gathered by the front end, waiting in the queue
	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] next_addr;
		logic [3:0]  len;
		logic [1:0]  page;
		logic [1:0]  index;
		logic [7:0]  opcode;
		logic [7:0]  disp;
		logic [7:0]  op_lo;
		logic [7:0]  op_hi;
	} z80d_raw_t;

	typedef struct packed {
		logic [15:0] instr_address;
		logic [3:0]  instr_length;
		logic [1:0]  page;
		logic [1:0]  index_reg;
		logic [7:0]  opcode;
		logic [7:0]  displacement;
		logic        has_displacement;
		logic [1:0]  imm_kind;
		logic [15:0] immediate;
		logic [15:0] branch_target;
		logic        undefined_op;
	} z80d_result_t;

	function automatic logic [1:0] imm_kind_of(input logic [1:0] pg, input logic [7:0] op);
		logic [1:0] f;
		logic [2:0] g;
		logic [2:0] h;
		logic [1:0] k;
		f = op[7:6];
		g = op[5:3];
		h = op[2:0];
		k = IMM_NONE;
		if (pg == PAGE_ED) begin
			k = (f == 2'd1 && h == 3'd3) ? IMM_WORD : IMM_NONE;
		end else if (pg == PAGE_BASE) begin
			if (f == 2'd0) begin
				case (h)
					3'd0: k = (g >= 3'd2) ? IMM_REL : IMM_NONE;
					3'd1: k = g[0] ? IMM_NONE : IMM_WORD;
					3'd2: k = (g >= 3'd4) ? IMM_WORD : IMM_NONE;
					3'd6: k = IMM_BYTE;
					default: k = IMM_NONE;
				endcase
			end else if (f == 2'd3) begin
				if (h == 3'd2 || h == 3'd4) k = IMM_WORD;
				else if (h == 3'd3)
					k = (g == 3'd0) ? IMM_WORD : ((g == 3'd2 || g == 3'd3) ? IMM_BYTE : IMM_NONE);
				else if (op == OP_CALL) k = IMM_WORD;
				else if (h == 3'd6) k = IMM_BYTE;
			end
		end
		return k;
	endfunction

	function automatic logic base_needs_disp(input logic [7:0] op);
		logic [1:0] f;
		logic [2:0] g;
		logic [2:0] h;
		logic r;
		f = op[7:6];
		g = op[5:3];
		h = op[2:0];
		r = 1'b0;
		if (op == OP_HALT) r = 1'b0;
		else if (f == 2'd1) r = (g == 3'd6) || (h == 3'd6);
		else if (f == 2'd2) r = (h == 3'd6);
		else if (f == 2'd0) r = (g == 3'd6) && (h == 3'd4 || h == 3'd5 || h == 3'd6);
		return r;
	endfunction

	function automatic logic is_undefined(input logic [1:0] pg, input logic [7:0] op);
		logic [1:0] f;
		logic [2:0] g;
		logic [2:0] h;
		logic r;
		f = op[7:6];
		g = op[5:3];
		h = op[2:0];
		r = 1'b0;
		if (pg == PAGE_CB) r = (f == 2'd0) && (g == 3'd6);
		else if (pg == PAGE_ED) begin
			if (f == 2'd0 || f == 2'd3) r = 1'b1;
			else if (f == 2'd1) begin
				if (h == 3'd6) r = (g == 3'd1) || (g >= 3'd4);
				else if (h == 3'd7) r = (g >= 3'd6);
			end else r = !((h < 3'd4) && (g >= 3'd4));
		end
		return r;
	endfunction

endpackage

// ===== hdl/z80d_if.sv =====
// ----------------------------------------------------------------------------
// z80d_byte_if / z80d_result_if
// Valid/ready channels for code bytes and decoded instructions.
// ----------------------------------------------------------------------------
interface z80d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface z80d_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] instr_address;
	logic [3:0]  instr_length;
	logic [1:0]  page;
	logic [1:0]  index_reg;
	logic [7:0]  opcode;
	logic signed [7:0] displacement;
	logic        has_displacement;
	logic [1:0]  imm_kind;
	logic [15:0] immediate;
	logic [15:0] branch_target;
	logic        undefined_op;
	modport source (output valid, output instr_address, output instr_length, output page,
		output index_reg, output opcode, output displacement, output has_displacement,
		output imm_kind, output immediate, output branch_target, output undefined_op,
		input ready);
	modport sink (input valid, input instr_address, input instr_length, input page,
		input index_reg, input opcode, input displacement, input has_displacement,
		input imm_kind, input immediate, input branch_target, input undefined_op,
		output ready);
endinterface

// ===== hdl/z80d_front.sv =====
// ----------------------------------------------------------------------------
// z80d_front
// Byte sequencer: tracks prefixes and pages, gathers operand bytes and pushes
// each completed instruction into the queue.
// ----------------------------------------------------------------------------
`include "z80_instruction_stream_decoder_macros.svh"

module z80d_front import z80d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        byte_valid,
	input  logic [7:0]  byte_data,
	output logic        byte_ready,
	output logic        push,
	output z80d_raw_t   push_data,
	input  logic        q_full
);

	logic [2:0]  phase_q;
	logic [15:0] pos_q;
	logic [15:0] start_q;
	logic [1:0]  page_q;
	logic [1:0]  index_q;
	logic [3:0]  count_q;
	logic [7:0]  op_q;
	logic [7:0]  disp_q;
	logic [7:0]  lo_q;

	logic        take;
	logic [15:0] pos_n;
	logic [3:0]  count_n;
	logic [2:0]  phase_n;
	logic [1:0]  page_n;
	logic [1:0]  index_n;
	logic [7:0]  op_n;
	logic [7:0]  disp_n;
	logic [7:0]  lo_n;
	logic [7:0]  hi_n;
	logic        done;

	assign byte_ready = !q_full;
	assign take       = byte_valid && byte_ready;
	assign pos_n      = pos_q + 16'd1;
	assign count_n    = (count_q == 4'd15) ? count_q : count_q + 4'd1;

	always_comb begin
		phase_n = phase_q;
		page_n  = page_q;
		index_n = index_q;
		op_n    = op_q;
		disp_n  = disp_q;
		lo_n    = lo_q;
		hi_n    = 8'd0;
		done    = 1'b0;
		unique case (phase_q)
			PH_CBDISP: begin
				disp_n  = byte_data;
				phase_n = PH_CBOP;
			end
			PH_CBOP: begin
				op_n = byte_data;
				done = 1'b1;
			end
			PH_DISP: begin
				disp_n = byte_data;
				if (imm_kind_of(page_q, op_q) != IMM_NONE) phase_n = PH_IMMLO;
				else done = 1'b1;
			end
			PH_IMMLO: begin
				lo_n = byte_data;
				if (imm_kind_of(page_q, op_q) == IMM_WORD) phase_n = PH_IMMHI;
				else done = 1'b1;
			end
			PH_IMMHI: begin
				hi_n = byte_data;
				done = 1'b1;
			end
			default: begin
				phase_n = PH_OP;
				if (phase_q != PH_EDOP && byte_data == OP_DD) index_n = IDX_IX;
				else if (phase_q != PH_EDOP && byte_data == OP_FD) index_n = IDX_IY;
				else if (phase_q != PH_EDOP && byte_data == OP_ED) begin
					page_n  = PAGE_ED;
					index_n = IDX_HL;
					phase_n = PH_EDOP;
				end else if (phase_q != PH_EDOP && byte_data == OP_CB) begin
					page_n  = PAGE_CB;
					phase_n = (index_q != IDX_HL) ? PH_CBDISP : PH_CBOP;
				end else begin
					if (phase_q != PH_EDOP) page_n = PAGE_BASE;
					op_n = byte_data;
					if (page_n == PAGE_BASE && index_q != IDX_HL && base_needs_disp(byte_data))
						phase_n = PH_DISP;
					else if (imm_kind_of(page_n, byte_data) != IMM_NONE)
						phase_n = PH_IMMLO;
					else done = 1'b1;
				end
			end
		endcase
	end

	assign push = take && done;
	always_comb begin
		push_data           = '0;
		push_data.addr      = start_q;
		push_data.next_addr = pos_n;
		push_data.len       = count_n;
		push_data.page      = page_n;
		push_data.index     = index_n;
		push_data.opcode    = op_n;
		push_data.disp      = disp_n;
		push_data.op_lo     = lo_n;
		push_data.op_hi     = hi_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OP;
			pos_q   <= 16'd0;
			start_q <= 16'd0;
			page_q  <= PAGE_BASE;
			index_q <= IDX_HL;
			count_q <= 4'd0;
			op_q    <= 8'd0;
			disp_q  <= 8'd0;
			lo_q    <= 8'd0;
		end else if (cfg_we) begin
			phase_q <= PH_OP;
			pos_q   <= cfg_wdata;
			start_q <= cfg_wdata;
			page_q  <= PAGE_BASE;
			index_q <= IDX_HL;
			count_q <= 4'd0;
			op_q    <= 8'd0;
			disp_q  <= 8'd0;
			lo_q    <= 8'd0;
		end else if (take) begin
			pos_q <= pos_n;
			if (done) begin
				// start the next instruction
				phase_q <= PH_OP;
				start_q <= pos_n;
				page_q  <= PAGE_BASE;
				index_q <= IDX_HL;
				count_q <= 4'd0;
				op_q    <= 8'd0;
				disp_q  <= 8'd0;
				lo_q    <= 8'd0;
			end else begin
				phase_q <= phase_n;
				page_q  <= page_n;
				index_q <= index_n;
				count_q <= count_n;
				op_q    <= op_n;
				disp_q  <= disp_n;
				lo_q    <= lo_n;
			end
		end
	end

	`Z80D_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !q_full)
	`Z80D_ASSERT_IMPL(a_phase_legal, clk, arst_n, 1'b1, phase_q <= PH_IMMHI)
	`Z80D_ASSERT_NEXT(a_pos_adv, clk, arst_n, take && !cfg_we, pos_q == $past(pos_q) + 16'd1)

endmodule

// ===== hdl/z80d_queue.sv =====
// ----------------------------------------------------------------------------
// z80d_queue
// Small FIFO of gathered instructions between the sequencer and the formatter.
// ----------------------------------------------------------------------------
`include "z80_instruction_stream_decoder_macros.svh"

module z80d_queue import z80d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  z80d_raw_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output z80d_raw_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	z80d_raw_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     cnt_q;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`Z80D_ASSERT_IMPL(a_no_overflow, clk, arst_n, full, !push)
	`Z80D_ASSERT_IMPL(a_no_underflow, clk, arst_n, !not_empty, !pop)
	`Z80D_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (AW+1)'(DEPTH))

endmodule

// ===== hdl/z80d_back.sv =====
// ----------------------------------------------------------------------------
// z80d_back
// Result formatter: classifies the queued instruction, forms operand, branch
// target and flags, and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "z80_instruction_stream_decoder_macros.svh"

module z80d_back import z80d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  z80d_raw_t    q_data,
	output logic         pop,
	output logic         res_valid,
	output z80d_result_t res,
	input  logic         res_ready
);

	z80d_result_t r_n;
	logic [1:0]   kind;
	logic         hasd;

	assign pop = q_valid && (!res_valid || res_ready);

	always_comb begin
		kind = imm_kind_of(q_data.page, q_data.opcode);
		hasd = (q_data.index != IDX_HL) && (q_data.page == PAGE_CB ||
			(q_data.page == PAGE_BASE && base_needs_disp(q_data.opcode)));
		r_n                  = '0;
		r_n.instr_address    = q_data.addr;
		r_n.instr_length     = q_data.len;
		r_n.page             = q_data.page;
		r_n.index_reg        = q_data.index;
		r_n.opcode           = q_data.opcode;
		r_n.displacement     = hasd ? q_data.disp : 8'd0;
		r_n.has_displacement = hasd;
		r_n.imm_kind         = kind;
		case (kind)
			IMM_BYTE: r_n.immediate = {8'd0, q_data.op_lo};
			IMM_REL: begin
				r_n.immediate     = {8'd0, q_data.op_lo};
				r_n.branch_target = q_data.next_addr + {{8{q_data.op_lo[7]}}, q_data.op_lo};
			end
			IMM_WORD: r_n.immediate = {q_data.op_hi, q_data.op_lo};
			default:  r_n.immediate = 16'd0;
		endcase
		r_n.undefined_op = is_undefined(q_data.page, q_data.opcode);
	end

	always_ff @(posedge clk) begin
		if (pop) res <= r_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (pop) res_valid <= 1'b1;
		else if (res_ready) res_valid <= 1'b0;
	end

	`Z80D_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res))
	`Z80D_ASSERT_NEXT(a_load, clk, arst_n, pop, res_valid)
	`Z80D_ASSERT_IMPL(a_disp_zero, clk, arst_n, res_valid && !res.has_displacement,
		res.displacement == 8'd0)

endmodule

// ===== hdl/z80_instruction_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// z80_instruction_stream_decoder
// Splits a Z80 byte stream into instructions with length, prefixes, operands.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in        in   valid/ready    code_byte
// out       out  valid/ready    instruction fields
// cfg       in   cfg_we         start_address
//
// One byte is accepted per cycle while the queue is not full.
// A completed instruction passes through a queue of QUEUE_DEPTH entries into
// the output register.
// Input stalls only when the queue is full; output stalls hold the register.
// Reset restarts decoding at address 0; a start_address write restarts it there.
module z80_instruction_stream_decoder import z80d_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	z80d_byte_if.sink     in_ch,
	z80d_result_if.source out_ch
);

	logic         push;
	z80d_raw_t    push_data;
	logic         q_full;
	logic         pop;
	logic         q_valid;
	z80d_raw_t    q_data;
	z80d_result_t res;

	z80d_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.byte_valid(in_ch.valid), .byte_data(in_ch.code_byte), .byte_ready(in_ch.ready),
		.push, .push_data, .q_full
	);

	z80d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .not_empty(q_valid), .pop_data(q_data)
	);

	z80d_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .pop,
		.res_valid(out_ch.valid), .res, .res_ready(out_ch.ready)
	);

	assign out_ch.instr_address    = res.instr_address;
	assign out_ch.instr_length     = res.instr_length;
	assign out_ch.page             = res.page;
	assign out_ch.index_reg        = res.index_reg;
	assign out_ch.opcode           = res.opcode;
	assign out_ch.displacement     = res.displacement;
	assign out_ch.has_displacement = res.has_displacement;
	assign out_ch.imm_kind         = res.imm_kind;
	assign out_ch.immediate        = res.immediate;
	assign out_ch.branch_target    = res.branch_target;
	assign out_ch.undefined_op     = res.undefined_op;

endmodule

// ===== dv/z80d_tb_if.sv =====
// ----------------------------------------------------------------------------
// z80d testbench channel notes
// The block's own byte and result interfaces are reused by the testbench;
// this file holds the testbench type used by the checker.
// ----------------------------------------------------------------------------
package z80d_tb_pkg;
	import z80d_pkg::*;

	// one expected decoded instruction, field by field
	typedef struct {
		logic [15:0] addr;
		logic [3:0]  len;
		logic [1:0]  page;
		logic [1:0]  index;
		logic [7:0]  opcode;
		logic [7:0]  disp;
		logic        has_disp;
		logic [1:0]  kind;
		logic [15:0] imm;
		logic [15:0] target;
		logic        undef;
	} instr_exp_t;
endpackage

// ===== dv/z80d_checker.sv =====
// ----------------------------------------------------------------------------
// z80d_checker
// Watches the byte and result channels, decodes the accepted byte stream on
// its own and compares each decoded instruction with the block's output.
// ----------------------------------------------------------------------------
module z80d_checker import z80d_pkg::*; import z80d_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	z80d_byte_if        in_ch,
	z80d_result_if      out_ch,
	output int          fail_count,
	output int          pending,
	output int          instr_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	instr_exp_t expected_instrs[$];

	logic [15:0] pos, first_addr;
	logic [2:0]  phase;
	logic [1:0]  pg, idx;
	logic [3:0]  cnt;
	logic [7:0]  lo, op, dsp;

	function automatic logic [1:0] operand_kind(logic [1:0] p, logic [7:0] o);
		logic [1:0] f;
		logic [2:0] g, h;
		f = o[7:6];
		g = o[5:3];
		h = o[2:0];
		if (p == PAGE_ED) return (f == 2'd1 && h == 3'd3) ? IMM_WORD : IMM_NONE;
		if (p != PAGE_BASE) return IMM_NONE;
		if (f == 2'd0) begin
			if (h == 3'd0) return g >= 3'd2 ? IMM_REL : IMM_NONE;
			if (h == 3'd1) return g[0] ? IMM_NONE : IMM_WORD;
			if (h == 3'd2) return g >= 3'd4 ? IMM_WORD : IMM_NONE;
			if (h == 3'd6) return IMM_BYTE;
			return IMM_NONE;
		end
		if (f == 2'd3) begin
			if (h == 3'd2 || h == 3'd4) return IMM_WORD;
			if (h == 3'd3) return g == 3'd0 ? IMM_WORD :
				((g == 3'd2 || g == 3'd3) ? IMM_BYTE : IMM_NONE);
			if (o == OP_CALL) return IMM_WORD;
			if (h == 3'd6) return IMM_BYTE;
		end
		return IMM_NONE;
	endfunction

	function automatic logic uses_hl_operand(logic [7:0] o);
		if (o == OP_HALT) return 1'b0;
		case (o[7:6])
			2'd1: return o[5:3] == 3'd6 || o[2:0] == 3'd6;
			2'd2: return o[2:0] == 3'd6;
			2'd0: return o[5:3] == 3'd6 && o[2:0] >= 3'd4 && o[2:0] <= 3'd6;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic no_mnemonic(logic [1:0] p, logic [7:0] o);
		logic [2:0] g, h;
		g = o[5:3];
		h = o[2:0];
		if (p == PAGE_CB) return o[7:6] == 2'd0 && g == 3'd6;
		if (p != PAGE_ED) return 1'b0;
		if (o[7:6] == 2'd0 || o[7:6] == 2'd3) return 1'b1;
		if (o[7:6] == 2'd1) begin
			if (h == 3'd6) return g == 3'd1 || g >= 3'd4;
			if (h == 3'd7) return g >= 3'd6;
			return 1'b0;
		end
		return !(h < 3'd4 && g >= 3'd4);
	endfunction

	task automatic restart_instr();
		phase = PH_OP;
		pg = PAGE_BASE;
		idx = IDX_HL;
		cnt = 4'd0;
		lo = 8'd0;
		op = 8'd0;
		dsp = 8'd0;
		first_addr = pos;
	endtask

	task automatic finish_instr(logic [7:0] hi);
		instr_exp_t e;
		e.kind = operand_kind(pg, op);
		e.has_disp = idx != IDX_HL && (pg == PAGE_CB || (pg == PAGE_BASE && uses_hl_operand(op)));
		e.addr = first_addr;
		e.len = cnt;
		e.page = pg;
		e.index = idx;
		e.opcode = op;
		e.disp = e.has_disp ? dsp : 8'd0;
		e.imm = (e.kind == IMM_BYTE || e.kind == IMM_REL) ? {8'd0, lo} :
			(e.kind == IMM_WORD ? {hi, lo} : 16'd0);
		e.target = e.kind == IMM_REL ? pos + {{8{lo[7]}}, lo} : 16'd0;
		e.undef = no_mnemonic(pg, op);
		expected_instrs.push_back(e);
		restart_instr();
	endtask

	task automatic after_op();
		if (pg == PAGE_BASE && idx != IDX_HL && uses_hl_operand(op)) phase = PH_DISP;
		else if (operand_kind(pg, op) != IMM_NONE) phase = PH_IMMLO;
		else finish_instr(8'd0);
	endtask

	task automatic take_byte(logic [7:0] b);
		pos = pos + 16'd1;
		if (cnt < 4'd15) cnt = cnt + 4'd1;
		case (phase)
			PH_CBDISP: begin
				dsp = b;
				phase = PH_CBOP;
			end
			PH_CBOP: begin
				op = b;
				finish_instr(8'd0);
			end
			PH_EDOP: begin
				op = b;
				after_op();
			end
			PH_DISP: begin
				dsp = b;
				if (operand_kind(pg, op) != IMM_NONE) phase = PH_IMMLO;
				else finish_instr(8'd0);
			end
			PH_IMMLO: begin
				lo = b;
				if (operand_kind(pg, op) == IMM_WORD) phase = PH_IMMHI;
				else finish_instr(8'd0);
			end
			PH_IMMHI: finish_instr(b);
			default: begin
				phase = PH_OP;
				if (b == OP_DD) idx = IDX_IX;
				else if (b == OP_FD) idx = IDX_IY;
				else if (b == OP_ED) begin
					pg = PAGE_ED;
					idx = IDX_HL;
					phase = PH_EDOP;
				end else if (b == OP_CB) begin
					pg = PAGE_CB;
					phase = idx != IDX_HL ? PH_CBDISP : PH_CBOP;
				end else begin
					pg = PAGE_BASE;
					op = b;
					after_op();
				end
			end
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
		fail_count++;
	endtask

	task automatic compare_instr();
		instr_exp_t e;
		if (expected_instrs.size() == 0) begin
			report("unexpected instruction", out_ch.instr_address, 0);
			return;
		end
		e = expected_instrs.pop_front();
		if (out_ch.instr_address !== e.addr) report("address", out_ch.instr_address, e.addr);
		if (out_ch.instr_length !== e.len) report("length", out_ch.instr_length, e.len);
		if (out_ch.page !== e.page) report("page", out_ch.page, e.page);
		if (out_ch.index_reg !== e.index) report("index_reg", out_ch.index_reg, e.index);
		if (out_ch.opcode !== e.opcode) report("opcode", out_ch.opcode, e.opcode);
		if (out_ch.displacement !== e.disp) report("displacement", out_ch.displacement, e.disp);
		if (out_ch.has_displacement !== e.has_disp)
			report("has_displacement", out_ch.has_displacement, e.has_disp);
		if (out_ch.imm_kind !== e.kind) report("imm_kind", out_ch.imm_kind, e.kind);
		if (out_ch.immediate !== e.imm) report("immediate", out_ch.immediate, e.imm);
		if (out_ch.branch_target !== e.target)
			report("branch_target", out_ch.branch_target, e.target);
		if (out_ch.undefined_op !== e.undef) report("undefined_op", out_ch.undefined_op, e.undef);
	endtask

	initial begin
		fail_count = 0;
		instr_seen = 0;
		pos = 16'd0;
		restart_instr();
	end

	assign pending = expected_instrs.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos = 16'd0;
			restart_instr();
			expected_instrs.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				compare_instr();
				instr_seen++;
			end
			if (cfg_we) begin
				pos = cfg_wdata;
				restart_instr();
			end else if (in_ch.valid && in_ch.ready) begin
				take_byte(in_ch.code_byte);
			end
		end
	end
endmodule

// ===== dv/tb_z80_instruction_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_z80_instruction_stream_decoder
// Feeds directed and random Z80 code streams through the decoder under random
// sender gaps and receiver stalls, over several start addresses.
// ----------------------------------------------------------------------------
module tb_z80_instruction_stream_decoder import z80d_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          fail_count, pending, instr_seen;
	int          bytes_sent;
	bit          long_hold;
	bit          stall_en;

	z80d_byte_if   in_ch();
	z80d_result_if out_ch();

	z80_instruction_stream_decoder u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	z80d_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending),
		.instr_seen(instr_seen)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stalls in stretches, plus one long hold-off
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) out_ch.ready <= 1'b0;
			else if (!stall_en) out_ch.ready <= 1'b1;
			else begin
				if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= $urandom_range(0, 3) != 0;
					default: out_ch.ready <= $urandom_range(0, 2) == 0;
				endcase
			end
		end
	end

	byte unsigned stream[$];

	task automatic send_stream();
		int burst;
		while (stream.size() > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && stream.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.code_byte <= stream[0];
				@(posedge clk);
				while (!in_ch.ready) @(posedge clk);
				void'(stream.pop_front());
				bytes_sent++;
				burst--;
			end
			if (stall_en && $urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_start(logic [15:0] a);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random instruction-like byte run: optional index prefixes, ED or CB, opcode, up to three bytes
	task automatic push_instr();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			repeat ($urandom_range(1, 2)) stream.push_back($urandom_range(0, 1) ? OP_DD : OP_FD);
		end
		r = $urandom_range(0, 9);
		if (r == 0) stream.push_back(OP_ED);
		else if (r == 1) stream.push_back(OP_CB);
		stream.push_back($urandom_range(0, 255));
		repeat ($urandom_range(0, 3)) stream.push_back($urandom_range(0, 255));
	endtask

	initial begin
		byte unsigned directed[$];
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		in_ch.valid = 1'b0;
		in_ch.code_byte = 8'd0;
		long_hold = 1'b0;
		stall_en = 1'b0;
		bytes_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: prefix chain, ED after index, CB paths, displacement plus
		// immediate, HALT, JR backwards, DJNZ, CALL, undefined ops
		directed = '{8'hDD, 8'hFD, 8'hDD, 8'hFD, 8'h21, 8'h34, 8'h12,
			8'hDD, 8'hED, 8'hB0, 8'hED, 8'h43, 8'hFF, 8'hEE, 8'hED, 8'h77,
			8'hCB, 8'hDD, 8'hCB, 8'h36, 8'h80, 8'hFD, 8'hCB, 8'h7F, 8'hFF,
			8'hDD, 8'h36, 8'h05, 8'hAA, 8'hDD, 8'h76, 8'h18, 8'h80, 8'h10, 8'h7F,
			8'hCD, 8'h00, 8'hFF, 8'hED, 8'hED, 8'hED, 8'hCB, 8'h00, 8'hFF};
		foreach (directed[i]) stream.push_back(directed[i]);
		// long prefix chain saturating length
		repeat (16) stream.push_back(OP_FD);
		stream.push_back(8'h00);
		send_stream();
		drain();

		stall_en = 1'b1;
		for (k = 0; k < 5; k++) begin
			case (k)
				0: set_start(16'hFFF8);
				1: set_start(16'h0000);
				2: set_start(16'hFFFF);
				default: set_start(16'($urandom_range(0, 16'hFFFF)));
			endcase
			repeat (28) push_instr();
			if (k == 4) repeat (30) stream.push_back($urandom_range(0, 255));
			if (k == 2) begin
				fork
					begin
						long_hold = 1'b1;
						repeat (60) @(posedge clk);
						long_hold = 1'b0;
					end
					send_stream();
				join
			end else send_stream();
			// partial instruction left over, abandoned by the next start write
			stream.push_back(OP_DD);
			send_stream();
			drain();
		end

		$display("run covered %0d code bytes and %0d decoded instructions", bytes_sent,
			instr_seen);
		$display("directed prefix, page, displacement and wrap cases plus random streams");
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
